// ----- hw/rtl/rgb_to_hsv_hsl_macros.svh -----
// assertion macros shared by the rtl
`ifndef RGB_TO_HSV_HSL_MACROS_SVH
`define RGB_TO_HSV_HSL_MACROS_SVH

// same-cycle implication, held off while in reset
`define RHSV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_hsl: same-cycle check failed");

// next-cycle implication, held off while in reset
`define RHSV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_hsl: next-cycle check failed");

`endif

// ----- hw/rtl/rhsv_pkg.sv -----
package rhsv_pkg;

  // field widths
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned HUE_W  = 15;
  localparam int unsigned SAT_W  = 17;
  localparam int unsigned VAL_W  = 8;
  localparam int unsigned LIT_W  = 9;

  // fixed point scaling of hue and saturation
  localparam int unsigned HUE_FRAC_BITS = 6;
  localparam int unsigned SAT_FRAC_BITS = 16;

  // hue numerator is 60 * span, span below 6 * 255
  localparam int unsigned SPAN_W    = 11;
  localparam int unsigned NUM_W     = 17;
  localparam int unsigned DEG_SECTOR = 60;

  // both quotients are produced one bit per stage over the same stage count
  localparam int unsigned DIV_STEPS = SAT_W;
  localparam int unsigned HUE_DVD_W = NUM_W + HUE_FRAC_BITS;
  localparam int unsigned SAT_DVD_W = CHAN_W + SAT_FRAC_BITS;

  // one divider stage: carried pixel data plus two partial divisions
  typedef struct packed {
    logic [CHAN_W-1:0]    hi;
    logic [CHAN_W-1:0]    lo;
    logic [CHAN_W-1:0]    d;
    logic [CHAN_W-1:0]    h_rem;
    logic [DIV_STEPS-1:0] h_work;
    logic [CHAN_W-1:0]    s_rem;
    logic [DIV_STEPS-1:0] s_work;
  } rhsv_stage_t;

endpackage

// ----- hw/rtl/rhsv_in_if.sv -----
interface rhsv_in_if;
  import rhsv_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ----- hw/rtl/rhsv_out_if.sv -----
interface rhsv_out_if;
  import rhsv_pkg::*;

  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [VAL_W-1:0] value;
  logic [LIT_W-1:0] lightness;

  modport source (output valid, hue, saturation, value, lightness, input ready);
  modport sink   (input valid, hue, saturation, value, lightness, output ready);
endinterface

// ----- hw/rtl/rhsv_div_stage.sv -----
module rhsv_div_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  rhsv_pkg::rhsv_stage_t in_stage,
  output logic                  out_valid,
  output rhsv_pkg::rhsv_stage_t out_stage
);
  import rhsv_pkg::*;

  rhsv_stage_t    stage_next;
  logic [CHAN_W:0] h_trial;
  logic [CHAN_W:0] s_trial;
  logic            h_bit;
  logic            s_bit;

  // one restoring step for hue (divisor d) and saturation (divisor hi)
  always_comb begin
    stage_next = in_stage;
    h_trial = {in_stage.h_rem, in_stage.h_work[DIV_STEPS-1]};
    s_trial = {in_stage.s_rem, in_stage.s_work[DIV_STEPS-1]};
    h_bit = (h_trial >= {1'b0, in_stage.d});
    s_bit = (s_trial >= {1'b0, in_stage.hi});
    stage_next.h_rem = h_bit ? CHAN_W'(h_trial - {1'b0, in_stage.d}) : h_trial[CHAN_W-1:0];
    stage_next.s_rem = s_bit ? CHAN_W'(s_trial - {1'b0, in_stage.hi}) : s_trial[CHAN_W-1:0];
    stage_next.h_work = {in_stage.h_work[DIV_STEPS-2:0], h_bit};
    stage_next.s_work = {in_stage.s_work[DIV_STEPS-2:0], s_bit};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end
endmodule

// ----- hw/rtl/rgb_to_hsv_hsl.sv -----
// channel     dir  fields                               handshake
// pixel_in    in   red, green, blue                     valid / ready
// pixel_out   out  hue, saturation, value, lightness    valid / ready
//
// one pixel per cycle sustained while pixel_out is not held; from acceptance to
// pixel_out.valid a pixel passes an input register, a max/min/sector stage, then 17
// restoring divider stages, one quotient bit each, shared by hue and saturation.
// rst is synchronous and clears only the valid bits.
// the whole pipeline holds while the last stage waits on pixel_out.ready.
`include "rgb_to_hsv_hsl_macros.svh"

module rgb_to_hsv_hsl (
  input logic      clk,
  input logic      rst,
  rhsv_in_if.sink  pixel_in,
  rhsv_out_if.source pixel_out
);
  import rhsv_pkg::*;

  logic              en;
  logic              in_vld;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  logic [CHAN_W-1:0]    hi;
  logic [CHAN_W-1:0]    lo;
  logic [CHAN_W-1:0]    d;
  logic [SPAN_W-1:0]    span;
  logic [NUM_W-1:0]     num;
  logic [HUE_DVD_W-1:0] h_dvd;
  logic [SAT_DVD_W-1:0] s_dvd;
  rhsv_stage_t          first_next;

  logic                 sec_vld;
  rhsv_stage_t          sec_stage;

  logic [DIV_STEPS:0] vld;
  rhsv_stage_t        st [0:DIV_STEPS];
  rhsv_stage_t        last;

  // global advance: everything moves unless the output is held
  assign en = !vld[DIV_STEPS] || pixel_out.ready;
  assign pixel_in.ready = en;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (en) begin
      in_vld <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= pixel_in.red;
      green <= pixel_in.green;
      blue  <= pixel_in.blue;
    end
  end

  // max, min, difference and hue sector span
  always_comb begin
    hi = red;
    lo = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    d = hi - lo;

    // ties resolve red first, then green
    if (red == hi) begin
      if (green >= blue) begin
        span = SPAN_W'(green - blue);
      end else begin
        span = SPAN_W'(6 * {3'b0, d}) - SPAN_W'(blue - green);
      end
    end else if (green == hi) begin
      span = SPAN_W'({d, 1'b0}) + SPAN_W'(blue) - SPAN_W'(red);
    end else begin
      span = SPAN_W'({d, 2'b0}) + SPAN_W'(red) - SPAN_W'(green);
    end
    num = NUM_W'(span * DEG_SECTOR);

    h_dvd = {num, HUE_FRAC_BITS'(0)};
    s_dvd = {d, SAT_FRAC_BITS'(0)};

    // seed both dividers; the top parts are already below their divisors
    first_next.hi     = hi;
    first_next.lo     = lo;
    first_next.d      = d;
    first_next.h_rem  = CHAN_W'(h_dvd[HUE_DVD_W-1:DIV_STEPS]);
    first_next.h_work = h_dvd[DIV_STEPS-1:0];
    first_next.s_rem  = CHAN_W'(s_dvd[SAT_DVD_W-1:DIV_STEPS]);
    first_next.s_work = s_dvd[DIV_STEPS-1:0];
  end

  // sector stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_vld <= 1'b0;
    end else if (en) begin
      sec_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec_stage <= first_next;
    end
  end

  assign vld[0] = sec_vld;
  assign st[0]  = sec_stage;

  // divider chain
  genvar i;
  generate
    for (i = 0; i < DIV_STEPS; i++) begin : g_div
      rhsv_div_stage u_stage (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .in_valid  (vld[i]),
        .in_stage  (st[i]),
        .out_valid (vld[i+1]),
        .out_stage (st[i+1])
      );
    end
  endgenerate

  // output mapping, grey and black pixels forced to zero
  assign last = st[DIV_STEPS];
  assign pixel_out.valid      = vld[DIV_STEPS];
  assign pixel_out.hue        = (last.d == '0) ? '0 : last.h_work[HUE_W-1:0];
  assign pixel_out.saturation = (last.hi == '0) ? '0 : last.s_work[SAT_W-1:0];
  assign pixel_out.value      = last.hi;
  assign pixel_out.lightness  = LIT_W'({1'b0, last.hi} + {1'b0, last.lo});

  // checks
  `RHSV_ASSERT_NEXT(a_accept_enters, clk, rst, pixel_in.valid && pixel_in.ready, in_vld)
  `RHSV_ASSERT_NEXT(a_stall_holds, clk, rst, !en, $stable(vld) && $stable(in_vld))
  `RHSV_ASSERT_NOW(a_light_ge_value, clk, rst, pixel_out.valid, pixel_out.lightness >= {1'b0, pixel_out.value})
endmodule
